// ===== design/fpe2_pkg.sv =====
// Shared constants, format codes and the 2^(k/64) table for the exp2 block.
`default_nettype none

package fpe2_pkg;

   // Format register codes
   localparam logic FMT_Q15_16 = 1'b0;
   localparam logic FMT_Q7_24  = 1'b1;

   // Field and datapath widths
   localparam int EXP_W    = 32;
   localparam int POWER_W  = 31;
   localparam int MANT_W   = 26;   // Q2.24 mantissa, at most 2.0
   localparam int SEG_BITS = 6;
   localparam int IDX_W    = SEG_BITS + 1;
   localparam int TAB_DEPTH = (1 << SEG_BITS) + 1;
   localparam int WGT_W    = 24 - SEG_BITS;   // widest weight (Q7.24)
   localparam int PROD_W   = WGT_W + MANT_W;
   localparam int SHIFT_W  = 16;

   localparam logic [POWER_W-1:0] SAT_MAX = {POWER_W{1'b1}};

   // 2^(k/64) in Q2.24, k = 0..64
   localparam logic [MANT_W-1:0] EXP2_TAB [0:TAB_DEPTH-1] = '{
      26'h1000000, 26'h102C9A3, 26'h1059B0D, 26'h1087451,
      26'h10B5586, 26'h10E3EC3, 26'h111301D, 26'h11429AA,
      26'h1172B83, 26'h11A35BE, 26'h11D4873, 26'h12063B8,
      26'h12387A6, 26'h126B456, 26'h129E9DF, 26'h12D285A,
      26'h1306FE0, 26'h133C08B, 26'h1371A73, 26'h13A7DB3,
      26'h13DEA64, 26'h14160A2, 26'h144E086, 26'h1486A2B,
      26'h14BFDAD, 26'h14F9B27, 26'h15342B5, 26'h156F473,
      26'h15AB07D, 26'h15E76F1, 26'h16247EB, 26'h1662388,
      26'h16A09E6, 26'h16DFB23, 26'h171F75E, 26'h175FEB5,
      26'h17A1147, 26'h17E2F33, 26'h1825899, 26'h1868D99,
      26'h18ACE54, 26'h18F1AE9, 26'h193737B, 26'h197D829,
      26'h19C4918, 26'h1A0C667, 26'h1A5503B, 26'h1A9E6B5,
      26'h1AE89F9, 26'h1B33A2B, 26'h1B7F76F, 26'h1BCC1E9,
      26'h1C199BD, 26'h1C67F12, 26'h1CB720D, 26'h1D072D4,
      26'h1D5818D, 26'h1DA9E60, 26'h1DFC973, 26'h1E502EE,
      26'h1EA4AFA, 26'h1EFA1BE, 26'h1F50765, 26'h1FA7C18,
      26'h2000000
   };

endpackage

`default_nettype wire

// ===== design/fpe2_interp.sv =====
// Table lookup and linear interpolation of the 2^fraction mantissa.
`default_nettype none

module fpe2_interp (
   input  wire logic                            format_select,
   input  wire logic [fpe2_pkg::EXP_W-1:0]      exponent,
   output logic      [fpe2_pkg::MANT_W-1:0]     mantissa
);

   logic [fpe2_pkg::IDX_W-1:0]  seg_idx;
   logic [fpe2_pkg::IDX_W-1:0]  seg_idx_next;
   logic [fpe2_pkg::WGT_W-1:0]  weight;
   logic [fpe2_pkg::MANT_W-1:0] tab_lo;
   logic [fpe2_pkg::MANT_W-1:0] tab_hi;
   logic [fpe2_pkg::MANT_W-1:0] seg_lo;
   logic [fpe2_pkg::MANT_W-1:0] seg_hi;
   logic [fpe2_pkg::MANT_W-1:0] seg_diff;
   logic [fpe2_pkg::PROD_W-1:0] prod;
   logic [fpe2_pkg::PROD_W-1:0] prod_shr;

   // Segment index and weight from the fraction bits
   always_comb begin
      if (format_select == fpe2_pkg::FMT_Q7_24) begin
         seg_idx = {1'b0, exponent[23:18]};
         weight  = exponent[17:0];
      end else begin
         seg_idx = {1'b0, exponent[15:10]};
         weight  = {8'b0, exponent[9:0]};
      end
   end

   assign seg_idx_next = seg_idx + 7'd1;
   assign tab_lo = fpe2_pkg::EXP2_TAB[seg_idx];
   assign tab_hi = fpe2_pkg::EXP2_TAB[seg_idx_next];

   // Q15.16 works on the table truncated to Q16
   always_comb begin
      if (format_select == fpe2_pkg::FMT_Q7_24) begin
         seg_lo = tab_lo;
         seg_hi = tab_hi;
      end else begin
         seg_lo = {8'b0, tab_lo[25:8]};
         seg_hi = {8'b0, tab_hi[25:8]};
      end
   end

   // Table is monotonic, so the difference is never negative
   assign seg_diff = seg_hi - seg_lo;
   assign prod     = {{fpe2_pkg::MANT_W{1'b0}}, weight} *
                     {{fpe2_pkg::WGT_W{1'b0}}, seg_diff};

   always_comb begin
      if (format_select == fpe2_pkg::FMT_Q7_24) begin
         prod_shr = prod >> 18;
      end else begin
         prod_shr = prod >> 10;
      end
   end

   // Interpolated value stays below the upper segment end
   assign mantissa = seg_lo + prod_shr[fpe2_pkg::MANT_W-1:0];

endmodule

`default_nettype wire

// ===== design/fixed_point_exp2_interp.sv =====
// Top level: 2^x in Q15.16 or Q7.24 with input register and result register.
//
//  channel   direction  handshake                     payload
//  req_      in         req_valid / req_stall         req_exponent[31:0] signed
//  rsp_      out        rsp_valid / rsp_stall         rsp_power[30:0], rsp_overflow
//  csr_      in         csr_write_enable              csr_write_data (format_select)
//
// rsp_valid rises once an accepted req beat reaches the result register; one beat per
// cycle sustained while rsp_stall is low. Lookup, one 18x26 multiply, add and barrel
// shift sit between the input register and the result register. Synchronous reset
// clears the valid bits and selects Q15.16. A stalled result holds the pipe; the input
// register still refills whenever the result register frees up in the same cycle.
`default_nettype none

module fixed_point_exp2_interp (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_stall,
   input  wire logic signed [fpe2_pkg::EXP_W-1:0]    req_exponent,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output logic             [fpe2_pkg::POWER_W-1:0]  rsp_power,
   output logic                                      rsp_overflow,
   input  wire logic                                 csr_write_enable,
   input  wire logic                                 csr_write_data
);

   logic                                 format_ff;
   logic                                 in_valid_ff;
   logic                                 in_valid_in;
   logic [fpe2_pkg::EXP_W-1:0]           exp_ff;
   logic                                 out_valid_ff;
   logic [fpe2_pkg::POWER_W-1:0]         power_ff;
   logic [fpe2_pkg::POWER_W-1:0]         power_in;
   logic                                 ovf_ff;
   logic                                 ovf_in;
   logic                                 advance;
   logic                                 req_take;
   logic [fpe2_pkg::MANT_W-1:0]          mant;
   logic signed [fpe2_pkg::SHIFT_W-1:0]  shift;
   logic [fpe2_pkg::SHIFT_W-1:0]         rshift;
   logic [fpe2_pkg::POWER_W-1:0]         right_val;
   logic [fpe2_pkg::POWER_W+fpe2_pkg::MANT_W-1:0] left_val;

   // Format register
   always_ff @(posedge clock) begin
      if (reset) begin
         format_ff <= fpe2_pkg::FMT_Q15_16;
      end else if (csr_write_enable) begin
         format_ff <= csr_write_data;
      end
   end

   // Handshake: result register frees when empty or taken
   assign advance   = !out_valid_ff || !rsp_stall;
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         exp_ff <= req_exponent;
      end
   end

   // Mantissa from table and interpolation
   fpe2_interp u_interp (
      .format_select (format_ff),
      .exponent      (exp_ff),
      .mantissa      (mant)
   );

   // Integer part as signed shift count
   always_comb begin
      if (format_ff == fpe2_pkg::FMT_Q7_24) begin
         shift = {{8{exp_ff[31]}}, exp_ff[31:24]};
      end else begin
         shift = exp_ff[31:16];
      end
   end

   assign rshift    = 16'(-shift);
   assign right_val = {5'b0, mant} >> rshift[4:0];
   assign left_val  = {{fpe2_pkg::POWER_W{1'b0}}, mant} << shift[4:0];

   // Shift with truncation on the right, saturation on the left
   always_comb begin
      if (shift[fpe2_pkg::SHIFT_W-1]) begin
         ovf_in = 1'b0;
         if (rshift >= 16'd31) begin
            power_in = '0;
         end else begin
            power_in = right_val;
         end
      end else if (shift >= 16'sd32 ||
                   (|left_val[fpe2_pkg::POWER_W+fpe2_pkg::MANT_W-1:fpe2_pkg::POWER_W])) begin
         ovf_in   = 1'b1;
         power_in = fpe2_pkg::SAT_MAX;
      end else begin
         ovf_in   = 1'b0;
         power_in = left_val[fpe2_pkg::POWER_W-1:0];
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && in_valid_ff) begin
         power_ff <= power_in;
         ovf_ff   <= ovf_in;
      end
   end

   assign rsp_valid    = out_valid_ff;
   assign rsp_power    = power_ff;
   assign rsp_overflow = ovf_ff;

   // Checks
   a_ovf_saturates: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && ovf_ff) |-> (power_ff == fpe2_pkg::SAT_MAX))
      else $error("overflow flagged without saturated power");

   a_stall_only_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_valid_ff)
      else $error("input stalled with empty input register");

   a_take_fills: assert property (@(posedge clock) disable iff (reset)
      req_take |=> in_valid_ff)
      else $error("accepted beat lost at input register");

   a_advance_fills: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && advance) |=> out_valid_ff)
      else $error("beat lost between input and result register");

endmodule

`default_nettype wire
